// ----- rtl/drp_pkg.sv -----
package drp_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int REG_W     = 32;
  localparam int DISP_W    = 16;
  localparam int COORD_W   = 12;
  localparam int PROD_W    = DISP_W + REG_W;
  localparam int DEN_W     = PROD_W + 1;
  localparam int DW        = PROD_W;
  localparam int QB        = 34;
  localparam int OUT_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int LANES     = 3;

  localparam logic signed [REG_W-1:0] RST_OFFSET_X   = -32'sd20971520;
  localparam logic signed [REG_W-1:0] RST_OFFSET_Y   = -32'sd15728640;
  localparam logic signed [REG_W-1:0] RST_FOCAL      = 32'sd32768000;
  localparam logic signed [REG_W-1:0] RST_INV_BASE   = 32'sd655360;
  localparam logic signed [REG_W-1:0] RST_SKEW       = 32'sd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_X,
    REG_OFFSET_Y,
    REG_FOCAL,
    REG_INV_BASE,
    REG_SKEW
  } cfg_reg_t;

  typedef struct packed {
    logic                            valid;
    logic [LANES-1:0][DW-1:0]        rem;
    logic [LANES-1:0][QB-1:0]        low;
    logic [LANES-1:0][QB-1:0]        quo;
    logic [DW-1:0]                   dvs;
    logic [LANES-1:0]                sat;
    logic [LANES-1:0]                neg;
    logic                            zero;
  } drp_div_t;

  typedef struct packed {
    logic                     valid;
    logic [LANES-1:0][OUT_W-1:0] pt;
    logic                     ok;
  } drp_res_t;

endpackage

// ----- rtl/drp_front.sv -----
module drp_front #(
  parameter int CoordBits = drp_pkg::COORD_BITS_DEF,
  parameter int FracBits  = drp_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   adv,
  input  logic                                   load,
  input  logic signed [drp_pkg::DISP_W-1:0]      disparity,
  input  logic        [drp_pkg::COORD_W-1:0]     column,
  input  logic        [drp_pkg::COORD_W-1:0]     row,
  input  logic signed [drp_pkg::REG_W-1:0]       offset_x,
  input  logic signed [drp_pkg::REG_W-1:0]       offset_y,
  input  logic signed [drp_pkg::REG_W-1:0]       focal_length,
  input  logic signed [drp_pkg::REG_W-1:0]       inverse_baseline,
  input  logic signed [drp_pkg::REG_W-1:0]       principal_skew_term,
  output drp_pkg::drp_div_t                      head
);

  localparam int CU = (CoordBits < drp_pkg::COORD_W) ? CoordBits : drp_pkg::COORD_W;
  localparam int SN = ((CU + FracBits + 1 > drp_pkg::REG_W) ?
                       CU + FracBits + 1 : drp_pkg::REG_W) + 1;
  localparam int NW = SN - 1;
  localparam int SH = drp_pkg::QB - FracBits - 5;
  localparam int CW = NW + drp_pkg::DW;
  localparam int DW = drp_pkg::DW;
  localparam int QB = drp_pkg::QB;
  localparam int DEN_W = drp_pkg::DEN_W;

  logic                              s1_v;
  logic signed [drp_pkg::PROD_W-1:0] s1_prod;
  logic        [CU-1:0]              s1_col;
  logic        [CU-1:0]              s1_row;

  logic                              s2_v;
  logic signed [DEN_W-1:0]           s2_den;
  logic signed [SN-1:0]              s2_num [drp_pkg::LANES];

  logic                              s3_v;
  logic        [DW-1:0]              s3_ud;
  logic        [NW-1:0]              s3_un  [drp_pkg::LANES];
  logic        [drp_pkg::LANES-1:0]  s3_neg;
  logic                              s3_zero;

  logic signed [DEN_W-1:0]           den_abs;
  logic signed [SN-1:0]              num_abs [drp_pkg::LANES];
  drp_pkg::drp_div_t                 head_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else if (adv) begin
      s1_v <= load;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_prod <= drp_pkg::PROD_W'(disparity) * drp_pkg::PROD_W'(inverse_baseline);
      s1_col  <= column[CU-1:0];
      s1_row  <= row[CU-1:0];
      s2_den  <= DEN_W'(s1_prod) + (DEN_W'(principal_skew_term) <<< 4);
      s2_num[0] <= (SN'(signed'({1'b0, s1_col})) <<< FracBits) + SN'(offset_x);
      s2_num[1] <= (SN'(signed'({1'b0, s1_row})) <<< FracBits) + SN'(offset_y);
      s2_num[2] <= SN'(focal_length);
      s3_ud   <= den_abs[DW-1:0];
      s3_zero <= (s2_den == '0);
      for (int i = 0; i < drp_pkg::LANES; i++) begin
        s3_un[i]  <= num_abs[i][NW-1:0];
        s3_neg[i] <= s2_num[i][SN-1] ^ s2_den[DEN_W-1];
      end
    end
  end

  always_comb begin
    den_abs = s2_den[DEN_W-1] ? -s2_den : s2_den;
    for (int i = 0; i < drp_pkg::LANES; i++) begin
      num_abs[i] = s2_num[i][SN-1] ? -s2_num[i] : s2_num[i];
    end
  end

  always_comb begin
    head_next       = '0;
    head_next.valid = s3_v;
    head_next.dvs   = s3_ud;
    head_next.neg   = s3_neg;
    head_next.zero  = s3_zero;
    for (int i = 0; i < drp_pkg::LANES; i++) begin
      head_next.sat[i] = CW'(s3_un[i] >> SH) >= CW'(s3_ud);
      head_next.rem[i] = head_next.sat[i] ? '0 : DW'(s3_un[i] >> SH);
      head_next.low[i] = QB'(s3_un[i][SH-1:0]) << (FracBits + 5);
      head_next.quo[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b0;
    end else if (adv) begin
      head <= head_next;
    end
  end

endmodule

// ----- rtl/drp_cell.sv -----
module drp_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  drp_pkg::drp_div_t cur,
  output drp_pkg::drp_div_t nxt
);

  localparam int DW = drp_pkg::DW;
  localparam int QB = drp_pkg::QB;

  logic [DW:0]               t  [drp_pkg::LANES];
  logic [drp_pkg::LANES-1:0] ge;
  drp_pkg::drp_div_t         nxt_next;

  always_comb begin
    nxt_next = cur;
    for (int i = 0; i < drp_pkg::LANES; i++) begin
      t[i]  = {cur.rem[i], cur.low[i][QB-1]};
      ge[i] = t[i] >= {1'b0, cur.dvs};
      nxt_next.rem[i] = ge[i] ? DW'(t[i] - {1'b0, cur.dvs}) : t[i][DW-1:0];
      nxt_next.low[i] = cur.low[i] << 1;
      nxt_next.quo[i] = {cur.quo[i][QB-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nxt.valid <= 1'b0;
    end else if (adv) begin
      nxt <= nxt_next;
    end
  end

endmodule

// ----- rtl/drp_back.sv -----
module drp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  drp_pkg::drp_div_t tail,
  output drp_pkg::drp_res_t res
);

  localparam int QB    = drp_pkg::QB;
  localparam int OUT_W = drp_pkg::OUT_W;
  localparam logic [QB-1:0] LIM_POS = QB'(32'h7FFF_FFFF);
  localparam logic [QB-1:0] LIM_NEG = QB'(32'h8000_0000);

  logic [QB:0]               rnd   [drp_pkg::LANES];
  logic [QB-1:0]             m     [drp_pkg::LANES];
  logic [QB-1:0]             lim   [drp_pkg::LANES];
  logic [OUT_W-1:0]          mag_next [drp_pkg::LANES];

  logic                      b1_v;
  logic [OUT_W-1:0]          b1_mag [drp_pkg::LANES];
  logic [drp_pkg::LANES-1:0] b1_neg;
  logic                      b1_zero;
  drp_pkg::drp_res_t         res_next;

  always_comb begin
    for (int i = 0; i < drp_pkg::LANES; i++) begin
      rnd[i] = {1'b0, tail.quo[i]} + (QB+1)'(1);
      m[i]   = rnd[i][QB:1];
      lim[i] = tail.neg[i] ? LIM_NEG : LIM_POS;
      mag_next[i] = (tail.sat[i] || m[i] > lim[i]) ? lim[i][OUT_W-1:0] : m[i][OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
    end else if (adv) begin
      b1_v <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_neg  <= tail.neg;
      b1_zero <= tail.zero;
      for (int i = 0; i < drp_pkg::LANES; i++) begin
        b1_mag[i] <= mag_next[i];
      end
    end
  end

  always_comb begin
    res_next       = '0;
    res_next.valid = b1_v;
    res_next.ok    = !b1_zero;
    for (int i = 0; i < drp_pkg::LANES; i++) begin
      if (b1_zero) begin
        res_next.pt[i] = '0;
      end else begin
        res_next.pt[i] = b1_neg[i] ? -b1_mag[i] : b1_mag[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (adv) begin
      res <= res_next;
    end
  end

endmodule

// ----- rtl/disparity_to_point_reprojection_core.sv -----
// Disparity to 3D point reprojection.
// Input channel: disparity, column, row with in_valid / in_stall; a request
// is taken on a clock edge with in_valid high and in_stall low.
// Output channel: point_x, point_y, point_z, valid_res with out_valid /
// out_stall. One result per request, in order.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write only while the block holds no request in flight.
// Throughput: one request per clock while in_stall is low. From the accepting
// edge to out_valid a request passes 4 front stages (multiply, denominator,
// magnitudes, divider load), a row of 34 divider cells, each retiring one
// quotient bit for all three coordinates, 2 rounding stages and the output
// register. Stall: the output register is backed by one skid entry; once that
// entry fills, in_stall rises and the whole pipeline holds until the output
// is taken. Reset clears all valid bits and loads the register defaults.
module disparity_to_point_reprojection_core #(
  parameter int COORD_BITS = drp_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = drp_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [drp_pkg::DISP_W-1:0]   disparity,
  input  logic        [drp_pkg::COORD_W-1:0]  column,
  input  logic        [drp_pkg::COORD_W-1:0]  row,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [drp_pkg::OUT_W-1:0]    point_x,
  output logic signed [drp_pkg::OUT_W-1:0]    point_y,
  output logic signed [drp_pkg::OUT_W-1:0]    point_z,
  output logic                                valid_res,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic        [drp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [drp_pkg::REG_W-1:0]    cfg_data
);

  logic signed [drp_pkg::REG_W-1:0] offset_x;
  logic signed [drp_pkg::REG_W-1:0] offset_y;
  logic signed [drp_pkg::REG_W-1:0] focal_length;
  logic signed [drp_pkg::REG_W-1:0] inverse_baseline;
  logic signed [drp_pkg::REG_W-1:0] principal_skew_term;

  logic              adv;
  logic              skid_v;
  drp_pkg::drp_res_t skid;
  drp_pkg::drp_res_t outr;
  drp_pkg::drp_res_t tail_res;
  drp_pkg::drp_div_t chain [drp_pkg::QB+1];

  assign cfg_ready = 1'b1;
  assign adv       = !skid_v;
  assign in_stall  = skid_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x            <= drp_pkg::RST_OFFSET_X;
      offset_y            <= drp_pkg::RST_OFFSET_Y;
      focal_length        <= drp_pkg::RST_FOCAL;
      inverse_baseline    <= drp_pkg::RST_INV_BASE;
      principal_skew_term <= drp_pkg::RST_SKEW;
    end else if (cfg_valid && cfg_ready) begin
      unique case (drp_pkg::cfg_reg_t'(cfg_index))
        drp_pkg::REG_OFFSET_X: offset_x            <= cfg_data;
        drp_pkg::REG_OFFSET_Y: offset_y            <= cfg_data;
        drp_pkg::REG_FOCAL:    focal_length        <= cfg_data;
        drp_pkg::REG_INV_BASE: inverse_baseline    <= cfg_data;
        drp_pkg::REG_SKEW:     principal_skew_term <= cfg_data;
        default: ;
      endcase
    end
  end

  drp_front #(
    .CoordBits(COORD_BITS),
    .FracBits (FRAC_BITS)
  ) u_front (
    .clk                (clk),
    .rst                (rst),
    .adv                (adv),
    .load               (in_valid),
    .disparity          (disparity),
    .column             (column),
    .row                (row),
    .offset_x           (offset_x),
    .offset_y           (offset_y),
    .focal_length       (focal_length),
    .inverse_baseline   (inverse_baseline),
    .principal_skew_term(principal_skew_term),
    .head               (chain[0])
  );

  for (genvar g = 0; g < drp_pkg::QB; g++) begin : g_cell
    drp_cell u_cell (
      .clk(clk),
      .rst(rst),
      .adv(adv),
      .cur(chain[g]),
      .nxt(chain[g+1])
    );
  end

  drp_back u_back (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .tail(chain[drp_pkg::QB]),
    .res (tail_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      outr.valid <= 1'b0;
      skid_v     <= 1'b0;
    end else if (!outr.valid || !out_stall) begin
      if (skid_v) begin
        outr   <= skid;
        skid_v <= 1'b0;
      end else begin
        outr       <= tail_res;
        outr.valid <= adv && tail_res.valid;
      end
    end else if (adv && tail_res.valid) begin
      skid   <= tail_res;
      skid_v <= 1'b1;
    end
  end

  assign out_valid = outr.valid;
  assign point_x   = outr.pt[0];
  assign point_y   = outr.pt[1];
  assign point_z   = outr.pt[2];
  assign valid_res = outr.ok;

endmodule

// ----- rtl/drp_checker.sv -----
module drp_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [drp_pkg::OUT_W-1:0]        point_x,
  input logic [drp_pkg::OUT_W-1:0]        point_y,
  input logic [drp_pkg::OUT_W-1:0]        point_z,
  input logic                             valid_res
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(point_x) && $stable(point_y)
      && $stable(point_z) && $stable(valid_res))
    else $error("stalled result changed");

  a_zero_den: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> point_x == '0 && point_y == '0 && point_z == '0)
    else $error("zero denominator gave nonzero point");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> $past(out_valid && out_stall))
    else $error("input stalled without a held result");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("channels active after reset");

endmodule

bind disparity_to_point_reprojection_core drp_checker u_chk (.*);
